FILE: rtl/core/brpd_pkg.sv
// Shared types and constants of the bitmap RLE palette decoder.
package brpd_pkg;

  // Request codes of the func field
  localparam logic [1:0] FUNC_PAL_WR = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_DATA   = 2'd2;

  // Escape codes of the second byte of a zero-count pair
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_RLE4_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_DOWN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 3'd4;

  localparam logic [12:0] IMAGE_WIDTH_RESET   = 13'd1;
  localparam logic [12:0] IMAGE_HEIGHT_RESET  = 13'd1;
  localparam logic [8:0]  PALETTE_COUNT_RESET = 9'd256;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_DX,
    PH_DY,
    PH_ABS,
    PH_PAD
  } phase_e;

  // Where the colors of a result come from
  typedef enum logic [1:0] {
    SRC_RAM,
    SRC_PAL0,
    SRC_ZERO
  } color_src_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } brpd_in_t;

  typedef struct packed {
    logic [11:0] span_row;
    logic [11:0] span_column;
    logic [7:0]  span_length;
    logic [23:0] color_even;
    logic [23:0] color_odd;
    logic        decode_done;
    logic        last_result;
  } brpd_out_t;

endpackage

FILE: rtl/core/brpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brpd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/bmp_rle_palette_decoder.sv
// Top level of the bitmap RLE8/RLE4 span decoder with a 24-bit palette.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o | in_req_i   (brpd_in_t)
//   out     | output    | out_valid_o / out_ready_i | out_req_o (brpd_out_t)
//   cfg     | input     | cfg_we_i, no wait       | cfg_idx_i, cfg_wdata_i
//
// One request enters per cycle unless stalled. In the input register the
// parser updates position and phase; then its spans sit in the result
// register, and the palette RAM read lands there with them. A request
// that causes two spans holds the result register until both are taken.
// Palette writes, image starts and bytes that yield no result move on even
// while a result waits; one with a result waits only for the result
// register. Reset leaves the decoder finished with the default configuration;
// the palette holds nothing until written, so no clearing pass is needed.
module bmp_rle_palette_decoder #(
  parameter int unsigned MAX_DIM       = 4096,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  brpd_pkg::brpd_in_t                 in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output brpd_pkg::brpd_out_t                out_req_o,
  input  logic                               cfg_we_i,
  input  logic [brpd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [brpd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  import brpd_pkg::*;

  // Position width holds 0..MAX_DIM; wider helpers for compares and sums.
  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned EW = (DW > 13) ? DW : 13;
  localparam int unsigned LW = (DW > 8) ? DW : 8;
  localparam int unsigned SW = LW + 1;
  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  // Index at or past the palette count or the depth reads entry zero.
  function automatic logic [AW-1:0] map_idx(input logic [7:0] idx, input logic [8:0] cnt);
    if ((9'(idx) >= cnt) || (9'(idx) >= 9'(PALETTE_DEPTH))) begin
      return '0;
    end
    return AW'(idx);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        rle4_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic        top_down_q;
  logic [8:0]  pal_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle4_q      <= 1'b0;
      width_q     <= IMAGE_WIDTH_RESET;
      height_q    <= IMAGE_HEIGHT_RESET;
      top_down_q  <= 1'b0;
      pal_count_q <= PALETTE_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RLE4_MODE:     rle4_q      <= cfg_wdata_i[0];
        CFG_IMAGE_WIDTH:   width_q     <= cfg_wdata_i[12:0];
        CFG_IMAGE_HEIGHT:  height_q    <= cfg_wdata_i[12:0];
        CFG_TOP_DOWN:      top_down_q  <= cfg_wdata_i[0];
        CFG_PALETTE_COUNT: pal_count_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Width and height saturate at MAX_DIM
  logic [DW-1:0] ew;
  logic [DW-1:0] eh;

  assign ew = (EW'(width_q)  > EW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(width_q);
  assign eh = (EW'(height_q) > EW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(height_q);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic     s1_valid_q;
  brpd_in_t s1_req_q;
  logic     s1_adv;

  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q <= in_req_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  phase_e        phase_q, phase_d;
  logic [7:0]    held_q, held_d;
  logic [7:0]    rem_q, rem_d;
  logic          pad_q, pad_d;
  logic [7:0]    dxh_q, dxh_d;
  logic [DW-1:0] col_q, col_d;
  logic [DW-1:0] row_q, row_d;
  logic          fin_q, fin_d;

  logic [7:0] b;
  logic       last;
  logic       is_data;
  logic       is_start;
  logic       is_pal;

  assign b        = s1_req_q.data_byte;
  assign last     = s1_req_q.last_byte;
  assign is_data  = s1_valid_q && (s1_req_q.func == FUNC_DATA) && !fin_q;
  assign is_start = s1_valid_q && (s1_req_q.func == FUNC_START);
  assign is_pal   = s1_valid_q && (s1_req_q.func == FUNC_PAL_WR);

  // Pixels taken by one absolute-run byte, and what stays after it
  logic [7:0] abs_n;
  logic [7:0] abs_left;
  logic [8:0] b_inc;

  assign abs_n    = rle4_q ? ((rem_q >= 8'd2) ? 8'd2 : rem_q) : ((rem_q != 8'd0) ? 8'd1 : 8'd0);
  assign abs_left = rem_q - abs_n;
  assign b_inc    = 9'(b) + 9'd1;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (is_start) begin
      phase_d = PH_FIRST;
    end else if (is_data) begin
      unique case (phase_q)
        PH_FIRST:  phase_d = last ? PH_FIRST : PH_SECOND;
        PH_SECOND: begin
          priority if (held_q != 8'd0 || b == ESC_EOL || b == ESC_EOB) begin
            phase_d = PH_FIRST;
          end else if (b == ESC_DELTA) begin
            phase_d = PH_DX;
          end else begin
            phase_d = PH_ABS;
          end
        end
        PH_DX:     phase_d = PH_DY;
        PH_DY:     phase_d = PH_FIRST;
        PH_ABS: begin
          if (abs_left == 8'd0) begin
            phase_d = pad_q ? PH_PAD : PH_FIRST;
          end
        end
        default:   phase_d = PH_FIRST;
      endcase
    end
  end

  // Command decode: span requests, moves and held values
  logic [7:0] a_req;
  color_src_e a_src;
  logic [7:0] b_req;
  logic       mv;
  logic       mv_nl;
  logic [7:0] mv_dx;
  logic [7:0] mv_dy;
  logic       fin_set;

  always_comb begin
    held_d  = held_q;
    rem_d   = rem_q;
    pad_d   = pad_q;
    dxh_d   = dxh_q;
    a_req   = 8'd0;
    a_src   = SRC_RAM;
    b_req   = 8'd0;
    mv      = 1'b0;
    mv_nl   = 1'b0;
    mv_dx   = 8'd0;
    mv_dy   = 8'd0;
    fin_set = 1'b0;
    if (is_start) begin
      held_d = 8'd0;
      rem_d  = 8'd0;
      pad_d  = 1'b0;
      dxh_d  = 8'd0;
    end else if (is_data) begin
      unique case (phase_q)
        PH_FIRST: begin
          held_d = b;
          // Cut short: the missing second byte reads as zero
          if (last) begin
            if (b != 8'd0) begin
              a_req = b;
              a_src = SRC_PAL0;
            end else begin
              mv    = 1'b1;
              mv_nl = 1'b1;
              mv_dy = 8'd1;
            end
          end
        end
        PH_SECOND: begin
          priority if (held_q != 8'd0) begin
            a_req = held_q;
          end else if (b == ESC_EOL) begin
            mv    = 1'b1;
            mv_nl = 1'b1;
            mv_dy = 8'd1;
          end else if (b == ESC_EOB) begin
            fin_set = 1'b1;
          end else if (b == ESC_DELTA) begin
            mv = last;
          end else begin
            rem_d = b;
            pad_d = rle4_q ? b_inc[1] : b[0];
            if (last) begin
              rem_d = 8'd0;
              a_req = b;
              a_src = SRC_PAL0;
            end
          end
        end
        PH_DX: begin
          dxh_d = b;
          mv    = last;
          mv_dx = b;
        end
        PH_DY: begin
          mv    = 1'b1;
          mv_dx = dxh_q;
          mv_dy = b;
        end
        PH_ABS: begin
          a_req = abs_n;
          rem_d = abs_left;
          // Fill the rest of a cut-short run with entry zero
          if (abs_left != 8'd0 && last) begin
            b_req = abs_left;
            rem_d = 8'd0;
          end
        end
        default: begin
          pad_d = 1'b0;
        end
      endcase
    end
  end

  // Span clipping: first span at the current column, second right after it
  logic          a_ok, b_ok;
  logic [DW-1:0] room_a, room_b;
  logic [7:0]    a_len, b_len;
  logic [DW-1:0] col_a, col_b;

  assign a_ok   = (a_req != 8'd0) && (row_q < eh) && (col_q < ew);
  assign room_a = ew - col_q;
  assign a_len  = (LW'(room_a) > LW'(a_req)) ? a_req : 8'(room_a);
  assign col_a  = a_ok ? col_q + DW'(a_len) : col_q;

  assign b_ok   = (b_req != 8'd0) && (row_q < eh) && (col_a < ew);
  assign room_b = ew - col_a;
  assign b_len  = (LW'(room_b) > LW'(b_req)) ? b_req : 8'(room_b);
  assign col_b  = b_ok ? col_a + DW'(b_len) : col_a;

  // Moves: end of line is a row step of one with the column cleared
  logic [SW-1:0] col_sum;
  logic [SW-1:0] row_sum;
  logic          mv_fin;
  logic [DW-1:0] mv_row;
  logic [DW-1:0] mv_col;

  assign col_sum = SW'(col_q) + SW'(mv_dx);
  assign row_sum = SW'(row_q) + SW'(mv_dy);
  assign mv_col  = mv_nl ? '0 : ((col_sum > SW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(col_sum));

  always_comb begin
    mv_fin = 1'b0;
    mv_row = row_q;
    if (top_down_q) begin
      if (row_sum >= SW'(eh)) begin
        mv_fin = 1'b1;
      end else begin
        mv_row = DW'(row_sum);
      end
    end else begin
      if (LW'(mv_dy) > LW'(row_q)) begin
        mv_fin = 1'b1;
      end else begin
        mv_row = DW'(LW'(row_q) - LW'(mv_dy));
      end
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    fin_d = fin_q;
    if (is_start) begin
      col_d = '0;
      row_d = (top_down_q || eh == '0) ? '0 : eh - DW'(1);
      fin_d = (eh == '0);
    end else if (is_data) begin
      fin_d = fin_set || last || (mv && mv_fin);
      if (mv) begin
        col_d = mv_col;
        row_d = mv_row;
      end else begin
        col_d = col_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      held_q  <= 8'd0;
      rem_q   <= 8'd0;
      pad_q   <= 1'b0;
      dxh_q   <= 8'd0;
      col_q   <= '0;
      row_q   <= '0;
      fin_q   <= 1'b1;
    end else if (s1_adv) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      rem_q   <= rem_d;
      pad_q   <= pad_d;
      dxh_q   <= dxh_d;
      col_q   <= col_d;
      row_q   <= row_d;
      fin_q   <= fin_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake between the input and result registers
  // ---------------------------------------------------------------------------
  logic s2_valid_q;
  logic s2_sel_q;
  logic s2_two_q;
  logic s2_free;
  logic has_res;
  logic s2_load;
  logic out_fire;

  assign out_fire = out_valid_o && out_ready_i;
  assign s2_free  = !s2_valid_q || (out_ready_i && (s2_sel_q || !s2_two_q));
  assign has_res  = is_data && (a_ok || b_ok || fin_d);
  assign s1_adv   = s1_valid_q && (!has_res || s2_free);
  assign s2_load  = s1_adv && has_res;

  // ---------------------------------------------------------------------------
  // Palette: two read ports for the even and odd nibble, entry zero in flops
  // ---------------------------------------------------------------------------
  logic          pal_we;
  logic [AW-1:0] raddr_even;
  logic [AW-1:0] raddr_odd;
  logic [23:0]   rd_even;
  logic [23:0]   rd_odd;
  logic [23:0]   pal0_q;

  assign pal_we     = s1_adv && is_pal && (9'(s1_req_q.palette_index) < 9'(PALETTE_DEPTH));
  assign raddr_even = map_idx(rle4_q ? {4'b0000, b[7:4]} : b, pal_count_q);
  assign raddr_odd  = map_idx(rle4_q ? {4'b0000, b[3:0]} : b, pal_count_q);

  brpd_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_even (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (AW'(s1_req_q.palette_index)),
    .wdata_i (s1_req_q.palette_color),
    .re_i    (s2_load),
    .raddr_i (raddr_even),
    .rdata_o (rd_even)
  );

  brpd_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_odd (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (AW'(s1_req_q.palette_index)),
    .wdata_i (s1_req_q.palette_color),
    .re_i    (s2_load),
    .raddr_i (raddr_odd),
    .rdata_o (rd_odd)
  );

  // Entry zero also lives in flops so a cut-short run can read it as a third port
  always_ff @(posedge clk_i) begin
    if (pal_we && s1_req_q.palette_index == 8'd0) begin
      pal0_q <= s1_req_q.palette_color;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: up to two spans per request
  // ---------------------------------------------------------------------------
  logic [11:0] s2_row_q;
  logic [11:0] s2_c0_q;
  logic [7:0]  s2_l0_q;
  color_src_e  s2_src0_q;
  logic [11:0] s2_c1_q;
  logic [7:0]  s2_l1_q;
  logic [23:0] s2_pal0_q;
  logic        s2_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_sel_q   <= 1'b0;
      s2_two_q   <= 1'b0;
    end else if (s2_load) begin
      s2_valid_q <= 1'b1;
      s2_sel_q   <= 1'b0;
      s2_two_q   <= a_ok && b_ok;
    end else if (out_fire) begin
      if (s2_two_q && !s2_sel_q) begin
        s2_sel_q <= 1'b1;
      end else begin
        s2_valid_q <= 1'b0;
        s2_sel_q   <= 1'b0;
      end
    end
  end

  // A lone second span only follows a first one, but keep the slot order generic
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_row_q  <= (a_ok || b_ok) ? 12'(row_q) : 12'd0;
      s2_c0_q   <= (a_ok || b_ok) ? 12'(col_q) : 12'd0;
      s2_l0_q   <= a_ok ? a_len : (b_ok ? b_len : 8'd0);
      s2_src0_q <= a_ok ? a_src : (b_ok ? SRC_PAL0 : SRC_ZERO);
      s2_c1_q   <= 12'(col_a);
      s2_l1_q   <= b_len;
      s2_pal0_q <= pal0_q;
      s2_done_q <= fin_d;
    end
  end

  assign out_valid_o = s2_valid_q;

  always_comb begin
    out_req_o.span_row    = s2_row_q;
    out_req_o.decode_done = s2_done_q;
    if (s2_sel_q) begin
      out_req_o.span_column = s2_c1_q;
      out_req_o.span_length = s2_l1_q;
      out_req_o.color_even  = s2_pal0_q;
      out_req_o.color_odd   = s2_pal0_q;
      out_req_o.last_result = 1'b1;
    end else begin
      out_req_o.span_column = s2_c0_q;
      out_req_o.span_length = s2_l0_q;
      out_req_o.last_result = !s2_two_q;
      unique case (s2_src0_q)
        SRC_RAM: begin
          out_req_o.color_even = rd_even;
          out_req_o.color_odd  = rd_odd;
        end
        SRC_PAL0: begin
          out_req_o.color_even = s2_pal0_q;
          out_req_o.color_odd  = s2_pal0_q;
        end
        default: begin
          out_req_o.color_even = 24'd0;
          out_req_o.color_odd  = 24'd0;
        end
      endcase
    end
  end

`ifndef SYNTH
  // A new request only lands on a full input register that is moving on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && s1_valid_q) |-> s1_adv)
    else $error("input register overwritten");

  // An empty span is only the completion report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.span_length == 8'd0)
      |-> (out_req_o.decode_done && out_req_o.last_result))
    else $error("empty span that is not a completion report");

  // The second slot is shown once, then the register drops back to slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && s2_sel_q) |=> !s2_sel_q)
    else $error("second span shown twice");

  // Palette writes and starts never take the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !is_data) |-> !s2_load)
    else $error("non-data request loaded a result");

  // Finishing an image always reports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && is_data && fin_d) |-> s2_load)
    else $error("image finished without a result");
`endif

endmodule

FILE: tb/sv/brpd_span_checker.sv
// Span checker for the RLE palette decoder: predicts spans per request and compares results.
`timescale 1ns / 100ps

module brpd_span_checker
  import brpd_pkg::*;
#(
  parameter int unsigned MAX_DIM       = 4096,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  brpd_in_t              in_req_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  brpd_out_t             out_req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatches_o,
  output int                    outstanding_o,
  output int                    spans_o,
  output int                    reports_o
);

  // Shadow of the decoder state and its registers
  logic [23:0] pal_mem [PALETTE_DEPTH];
  phase_e      parse_ph     = PH_FIRST;
  logic [7:0]  held_cmd     = '0;
  logic [7:0]  run_left     = '0;
  logic        pad_due      = 1'b0;
  logic [7:0]  dx_hold      = '0;
  logic [12:0] col_pos      = '0;
  logic [12:0] row_pos      = '0;
  logic        finished     = 1'b1;

  logic        rle4_cfg     = 1'b0;
  logic [12:0] width_cfg    = IMAGE_WIDTH_RESET;
  logic [12:0] height_cfg   = IMAGE_HEIGHT_RESET;
  logic        top_down_cfg = 1'b0;
  logic [8:0]  pal_cnt_cfg  = PALETTE_COUNT_RESET;

  brpd_out_t   step_res[$];
  brpd_out_t   expected_spans[$];
  int          mismatches   = 0;
  int          outstanding  = 0;
  int          spans_seen   = 0;
  int          reports_seen = 0;

  assign mismatches_o  = mismatches;
  assign outstanding_o = outstanding;
  assign spans_o       = spans_seen;
  assign reports_o     = reports_seen;

  function automatic int eff_width();
    return (width_cfg > MAX_DIM) ? MAX_DIM : int'(width_cfg);
  endfunction

  function automatic int eff_height();
    return (height_cfg > MAX_DIM) ? MAX_DIM : int'(height_cfg);
  endfunction

  // Indices past the loaded count fall back to entry zero
  function automatic logic [23:0] pal_color(input int idx);
    if (idx >= int'(pal_cnt_cfg) || idx >= PALETTE_DEPTH) idx = 0;
    return pal_mem[idx];
  endfunction

  // Clip a run at the row end and queue it as one span
  task automatic emit_span(input int req, input logic [23:0] even_c, input logic [23:0] odd_c);
    int        w;
    int        n;
    brpd_out_t s;
    w = eff_width();
    if (int'(row_pos) >= eff_height() || int'(col_pos) >= w || req == 0) return;
    n = w - int'(col_pos);
    if (n > req) n = req;
    s = '0;
    s.span_row    = row_pos[11:0];
    s.span_column = col_pos[11:0];
    s.span_length = n[7:0];
    s.color_even  = even_c;
    s.color_odd   = odd_c;
    step_res.push_back(s);
    col_pos = col_pos + n[12:0];
  endtask

  task automatic next_line();
    col_pos = '0;
    if (top_down_cfg) begin
      if (int'(row_pos) + 1 >= eff_height()) finished = 1'b1;
      else row_pos = row_pos + 13'd1;
    end else begin
      if (row_pos == '0) finished = 1'b1;
      else row_pos = row_pos - 13'd1;
    end
  endtask

  task automatic apply_delta(input int dx, input int dy);
    int c;
    c = int'(col_pos) + dx;
    if (c > MAX_DIM) c = MAX_DIM;
    col_pos = c[12:0];
    if (top_down_cfg) begin
      if (int'(row_pos) + dy >= eff_height()) finished = 1'b1;
      else row_pos = row_pos + dy[12:0];
    end else begin
      if (dy > int'(row_pos)) finished = 1'b1;
      else row_pos = row_pos - dy[12:0];
    end
  endtask

  task automatic second_byte(input logic [7:0] sec, input logic last);
    int nbytes;
    parse_ph = PH_FIRST;
    if (held_cmd != '0) begin
      if (rle4_cfg) emit_span(held_cmd, pal_color(sec[7:4]), pal_color(sec[3:0]));
      else emit_span(held_cmd, pal_color(sec), pal_color(sec));
      return;
    end
    case (sec)
      ESC_EOL: next_line();
      ESC_EOB: finished = 1'b1;
      ESC_DELTA: begin
        parse_ph = PH_DX;
        if (last) apply_delta(0, 0);
      end
      default: begin
        run_left = sec;
        nbytes   = rle4_cfg ? (int'(sec) + 1) / 2 : int'(sec);
        pad_due  = nbytes[0];
        parse_ph = PH_ABS;
        if (last) begin
          run_left = '0;
          emit_span(sec, pal_color(0), pal_color(0));
        end
      end
    endcase
  endtask

  task automatic predict_request(input brpd_in_t req);
    int          n;
    int          h;
    logic        last;
    logic [7:0]  b;
    brpd_out_t   s;
    step_res.delete();
    last = req.last_byte;
    b    = req.data_byte;
    case (req.func)
      FUNC_PAL_WR: begin
        if (req.palette_index < PALETTE_DEPTH) pal_mem[req.palette_index] = req.palette_color;
        return;
      end
      FUNC_START: begin
        h        = eff_height();
        parse_ph = PH_FIRST;
        held_cmd = '0;
        run_left = '0;
        pad_due  = 1'b0;
        dx_hold  = '0;
        col_pos  = '0;
        row_pos  = (top_down_cfg || h == 0) ? 13'd0 : 13'(h - 1);
        finished = (h == 0);
        return;
      end
      FUNC_DATA: ;
      default: return;
    endcase
    if (finished) return;

    case (parse_ph)
      PH_FIRST: begin
        held_cmd = b;
        parse_ph = PH_SECOND;
        if (last) second_byte(8'h00, 1'b1);
      end
      PH_SECOND: second_byte(b, last);
      PH_DX: begin
        dx_hold  = b;
        parse_ph = PH_DY;
        if (last) apply_delta(b, 0);
      end
      PH_DY: begin
        apply_delta(dx_hold, b);
        parse_ph = PH_FIRST;
      end
      PH_ABS: begin
        if (rle4_cfg) begin
          n = (run_left >= 8'd2) ? 2 : int'(run_left);
          emit_span(n, pal_color(b[7:4]), pal_color(b[3:0]));
        end else begin
          n = (run_left != '0) ? 1 : 0;
          emit_span(n, pal_color(b), pal_color(b));
        end
        run_left = run_left - n[7:0];
        if (run_left == '0) begin
          parse_ph = pad_due ? PH_PAD : PH_FIRST;
        end else if (last) begin
          // zero bytes fill the rest of the run
          emit_span(run_left, pal_color(0), pal_color(0));
          run_left = '0;
        end
      end
      default: begin
        pad_due  = 1'b0;
        parse_ph = PH_FIRST;
      end
    endcase

    if (last) finished = 1'b1;
    if (step_res.size() == 0 && finished) step_res.push_back('0);
    foreach (step_res[i]) begin
      s             = step_res[i];
      s.decode_done = finished;
      s.last_result = (i == step_res.size() - 1);
      expected_spans.push_back(s);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(input brpd_out_t got);
    brpd_out_t want;
    if (expected_spans.size() == 0) begin
      $error("result with nothing expected: row %0d column %0d length %0d",
             got.span_row, got.span_column, got.span_length);
      mismatches++;
      return;
    end
    want = expected_spans.pop_front();
    if (want.span_length == '0) reports_seen++;
    else spans_seen++;
    check_field("span_row", want.span_row, got.span_row);
    check_field("span_column", want.span_column, got.span_column);
    check_field("span_length", want.span_length, got.span_length);
    check_field("color_even", want.color_even, got.color_even);
    check_field("color_odd", want.color_odd, got.color_odd);
    check_field("decode_done", want.decode_done, got.decode_done);
    check_field("last_result", want.last_result, got.last_result);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_ph     = PH_FIRST;
      held_cmd     = '0;
      run_left     = '0;
      pad_due      = 1'b0;
      dx_hold      = '0;
      col_pos      = '0;
      row_pos      = '0;
      finished     = 1'b1;
      rle4_cfg     = 1'b0;
      width_cfg    = IMAGE_WIDTH_RESET;
      height_cfg   = IMAGE_HEIGHT_RESET;
      top_down_cfg = 1'b0;
      pal_cnt_cfg  = PALETTE_COUNT_RESET;
      expected_spans.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RLE4_MODE:     rle4_cfg     = cfg_wdata_i[0];
          CFG_IMAGE_WIDTH:   width_cfg    = cfg_wdata_i;
          CFG_IMAGE_HEIGHT:  height_cfg   = cfg_wdata_i;
          CFG_TOP_DOWN:      top_down_cfg = cfg_wdata_i[0];
          CFG_PALETTE_COUNT: pal_cnt_cfg  = cfg_wdata_i[8:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_request(in_req_i);
      if (out_valid_i && out_ready_i) compare_result(out_req_i);
    end
    outstanding = expected_spans.size();
  end

endmodule

FILE: tb/sv/bmp_rle_palette_decoder_test.sv
// Top of the RLE palette decoder testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module bmp_rle_palette_decoder_test;
  import brpd_pkg::*;

  // The package leaves the fourth request code unnamed; the block must ignore it
  localparam logic [1:0] FUNC_NONE  = 2'd3;
  localparam int         RAND_TOTAL = 360;
  localparam int         HOLD_LEN   = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  brpd_in_t              in_req_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  brpd_out_t             out_req_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  int mismatches;
  int outstanding;
  int spans_seen;
  int reports_seen;

  // Flow control knobs; the receiver process reads them, so update them with NBAs
  int send_idle_pct = 14;
  int recv_idle_pct = 65;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  int         sent_count   = 0;
  int         images_made  = 0;
  int         settings_used = 0;
  logic       cur_rle4     = 1'b0;
  logic [7:0] cmd_bytes[$];

  always #4 clk_i = ~clk_i;

  bmp_rle_palette_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  brpd_span_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_req_i      (in_req_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_req_i     (out_req_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .spans_o       (spans_seen),
    .reports_o     (reports_seen)
  );

  // Receiver: a new hold request drops ready until the hold_left countdown ends, so
  // the result register fills and the input side backs up; otherwise stall at random.
  always @(negedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen   <= hold_reqs;
      hold_left   <= HOLD_LEN;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Random filler for the fields a request does not use
  function automatic brpd_in_t noise_req();
    brpd_in_t r;
    r.func          = FUNC_DATA;
    r.data_byte     = 8'($urandom);
    r.last_byte     = 1'($urandom_range(1));
    r.palette_index = 8'($urandom);
    r.palette_color = 24'($urandom);
    return r;
  endfunction

  // Offer one request and hold it until the decoder takes it; idle first at random.
  // Call and return at a falling edge.
  task automatic push_req(input brpd_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic put_data(input logic [7:0] b, input logic last);
    brpd_in_t r;
    r           = noise_req();
    r.data_byte = b;
    r.last_byte = last;
    push_req(r);
  endtask

  task automatic put_func(input logic [1:0] code);
    brpd_in_t r;
    r      = noise_req();
    r.func = code;
    push_req(r);
  endtask

  task automatic write_palette(input logic [7:0] idx, input logic [23:0] color);
    brpd_in_t r;
    r               = noise_req();
    r.func          = FUNC_PAL_WR;
    r.palette_index = idx;
    r.palette_color = color;
    push_req(r);
  endtask

  // Write all five registers back to back; the enable stays high across them
  task automatic set_config(input logic rle4, input int w, input int h, input logic td,
                            input int pc);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RLE4_MODE;
    cfg_wdata_i <= CFG_DATA_W'(rle4);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_IMAGE_WIDTH;
    cfg_wdata_i <= CFG_DATA_W'(w);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_IMAGE_HEIGHT;
    cfg_wdata_i <= CFG_DATA_W'(h);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_TOP_DOWN;
    cfg_wdata_i <= CFG_DATA_W'(td);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_PALETTE_COUNT;
    cfg_wdata_i <= CFG_DATA_W'(pc);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_rle4     = rle4;
    settings_used++;
  endtask

  // Drop valid, wait for every expected span, then let a request that makes no
  // span leave the two pipeline stages before the registers may change.
  task automatic settle();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (outstanding != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);
  endtask

  // Build one well-formed command (or one stray byte) into cmd_bytes
  task automatic build_cmd();
    int pick;
    int cnt;
    int nbytes;
    cmd_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 35) begin
      // encoded run
      cnt = ($urandom_range(6) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
      cmd_bytes.push_back(8'(cnt));
      cmd_bytes.push_back(8'($urandom));
    end else if (pick < 47) begin
      cmd_bytes.push_back(8'h00);
      cmd_bytes.push_back(ESC_EOL);
    end else if (pick < 58) begin
      cmd_bytes.push_back(8'h00);
      cmd_bytes.push_back(ESC_DELTA);
      cmd_bytes.push_back(($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(6)));
      cmd_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1)));
    end else if (pick < 90) begin
      // absolute run, padded to a word
      cnt    = ($urandom_range(11) == 0) ? $urandom_range(3, 64) : $urandom_range(3, 12);
      nbytes = cur_rle4 ? (cnt + 1) / 2 : cnt;
      cmd_bytes.push_back(8'h00);
      cmd_bytes.push_back(8'(cnt));
      repeat (nbytes) cmd_bytes.push_back(8'($urandom));
      if (nbytes % 2 == 1) cmd_bytes.push_back(8'($urandom));
    end else begin
      // stray byte, knocks the parser out of step
      cmd_bytes.push_back(8'($urandom));
    end
  endtask

  // Send cmd_bytes; when cutting short, stop at a random byte and mark it last
  task automatic flush_cmd(input logic cut);
    int stop;
    stop = cut ? $urandom_range(cmd_bytes.size() - 1) : cmd_bytes.size() - 1;
    for (int i = 0; i <= stop; i++) put_data(cmd_bytes[i], cut && (i == stop));
  endtask

  // One image: start, a few commands, then end of bitmap, a cut-short command,
  // or nothing at all (the next start abandons it)
  task automatic gen_image();
    int ncmd;
    int ending;
    put_func(FUNC_START);
    ncmd   = $urandom_range(1, 8);
    ending = $urandom_range(99);
    for (int i = 0; i < ncmd; i++) begin
      if ($urandom_range(19) == 0) begin
        if ($urandom_range(1) == 0) write_palette(8'($urandom), 24'($urandom));
        else put_func(FUNC_NONE);
      end
      build_cmd();
      flush_cmd(ending < 30 && i == ncmd - 1);
    end
    if (ending >= 30 && ending < 75) begin
      put_data(8'h00, 1'b0);
      put_data(ESC_EOB, 1'($urandom_range(1)));
    end
    // a stray byte after the commands is dropped once decoding is over
    if ($urandom_range(9) == 0) put_data(8'($urandom), 1'b0);
    images_made++;
  endtask

  function automatic int pick_dim(input int typical);
    case ($urandom_range(9))
      0:       return 1;
      1:       return 4096;
      default: return $urandom_range(1, typical);
    endcase
  endfunction

  initial begin
    int rand_start;
    int quota;
    int sess;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_RLE4_MODE;
    cfg_wdata_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed RLE8 image: 8 wide, 4 high, bottom-up, full palette
    set_config(1'b0, 8, 4, 1'b0, 256);

    // Load every palette entry so no lookup ever hits an unwritten one
    write_palette(8'd0, 24'h000000);
    write_palette(8'd255, 24'hFFFFFF);
    for (int i = 1; i < 255; i++) write_palette(8'(i), 24'($urandom));

    put_func(FUNC_START);
    put_data(8'h03, 1'b0);        // run of 3 in entry 0
    put_data(8'h00, 1'b0);
    put_data(8'hFF, 1'b0);        // run of 255, clipped at the row end
    put_data(8'hFF, 1'b0);
    put_data(8'h00, 1'b0);        // end of line
    put_data(ESC_EOL, 1'b0);
    put_data(8'h00, 1'b0);        // delta right 5, down 1
    put_data(ESC_DELTA, 1'b0);
    put_data(8'h05, 1'b0);
    put_data(8'h01, 1'b0);
    put_data(8'h00, 1'b0);        // absolute run of 3 with a pad byte
    put_data(8'h03, 1'b0);
    put_data(8'h80, 1'b0);
    put_data(8'h7F, 1'b0);
    put_data(8'h01, 1'b0);
    put_data(8'h00, 1'b0);
    put_func(FUNC_NONE);          // unused request code, no effect
    put_data(8'h00, 1'b0);        // end of bitmap: completion report only
    put_data(ESC_EOB, 1'b0);
    put_data(8'h2A, 1'b0);        // dropped, decoding is over
    settle();

    // Directed RLE4: widest row, top-down, only three palette entries valid
    set_config(1'b1, 4096, 2, 1'b1, 3);
    put_func(FUNC_START);
    put_data(8'h05, 1'b0);        // nibble run alternating entries 10 (past count) and 2
    put_data(8'hA2, 1'b0);
    put_data(8'h00, 1'b0);        // absolute run of 3 nibbles, two bytes, no pad
    put_data(8'h03, 1'b0);
    put_data(8'h12, 1'b0);
    put_data(8'h30, 1'b0);
    put_data(8'h00, 1'b0);        // absolute run cut short right after its count
    put_data(8'h04, 1'b1);
    settle();

    // Random part: sessions of images under one register setting each.
    // Sender idles 14%/receiver 65%, then the reverse, then neither.
    rand_start = sent_count;
    sess       = 0;
    while (sent_count - rand_start < RAND_TOTAL) begin
      if (sent_count - rand_start < RAND_TOTAL / 3) begin
        send_idle_pct  = 14;
        recv_idle_pct <= 65;
      end else if (sent_count - rand_start < 2 * RAND_TOTAL / 3) begin
        send_idle_pct  = 65;
        recv_idle_pct <= 14;
      end else begin
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
      end
      settle();
      case (sess)
        0:       set_config(1'b0, 4096, 4096, 1'b0, 256);
        1:       set_config(1'b1, 1, 1, 1'b1, 1);
        2:       set_config(1'b0, 4096, 1, 1'b1, 256);
        3:       set_config(1'b1, 4096, 4096, 1'b1, 256);
        default: set_config(1'($urandom_range(1)), pick_dim(40), pick_dim(16),
                            1'($urandom_range(1)),
                            ($urandom_range(3) == 0) ? 256 : $urandom_range(1, 256));
      endcase
      // Block the receiver in two sessions so results back up, one with the widest rows
      if (sess == 2 || sess == 7) hold_reqs <= hold_reqs + 1;
      quota = sent_count + $urandom_range(40, 70);
      while (sent_count < quota && sent_count - rand_start < RAND_TOTAL) gen_image();
      sess++;
    end

    settle();
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
    $display("Sent %0d requests: %0d images under %0d register settings, RLE8 and RLE4.",
             sent_count, images_made, settings_used);
    $display("Compared %0d pixel spans and %0d completion reports, with long output stalls.",
             spans_seen, reports_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("bmp_rle_palette_decoder_test OK");
    end else begin
      $display("bmp_rle_palette_decoder_test NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("bmp_rle_palette_decoder_test NOT OK");
    $finish;
  end

endmodule
